### design/ign3d_pkg.sv
`default_nettype none
package ign3d_pkg;

	localparam int COORD_W   = 24;
	localparam int FRAC_BITS = 16;
	localparam int INT_W     = 8;
	localparam int OUT_W     = 18;
	localparam int PERM_SIZE = 256;
	localparam int QUEUE_DEPTH_DEF = 2;

	// One lattice item: integer cell indexes and fractions of the three axes.
	typedef struct packed {
		logic [INT_W-1:0]     xi;
		logic [INT_W-1:0]     yi;
		logic [INT_W-1:0]     zi;
		logic [FRAC_BITS-1:0] xf;
		logic [FRAC_BITS-1:0] yf;
		logic [FRAC_BITS-1:0] zf;
	} item_t;

	// Queue status seen by the front end.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam logic [7:0] PERM_ROM [PERM_SIZE] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
		8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
		8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
		8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
		8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
		8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
		8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
		8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
		8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
		8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
		8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
		8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
		8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
		8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
		8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
		8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
		8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
		8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
		8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
		8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
		8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
		8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
		8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
		8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
		8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
		8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
		8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
		8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
		8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
		8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
		8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
		8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
	};

	// Gradient dot product for one corner. Bit 3 picks y over x for the first
	// term; the second term is y for the low four codes, x for codes 12 and 14
	// and z otherwise. Bits 0 and 1 negate the two terms.
	function automatic logic signed [18:0] grad_sum(input logic [3:0] h,
			input logic signed [17:0] ox, input logic signed [17:0] oy,
			input logic signed [17:0] oz);
		logic signed [18:0] pa;
		logic signed [18:0] pb;
		pa = 19'(h[3] ? oy : ox);
		if (h[3:2] == 2'b00) begin
			pb = 19'(oy);
		end else if (h == 4'hC || h == 4'hE) begin
			pb = 19'(ox);
		end else begin
			pb = 19'(oz);
		end
		return (h[0] ? -pa : pa) + (h[1] ? -pb : pb);
	endfunction

endpackage
`default_nettype wire

### design/ign3d_front.sv
`default_nettype none
module ign3d_front import ign3d_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [COORD_W-1:0] x_coord,
	input  wire logic [COORD_W-1:0] y_coord,
	input  wire logic [COORD_W-1:0] z_coord,
	input  wire q_stat_t            q_stat,
	output logic                    busy,
	output logic                    push,
	output item_t                   item
);

	logic  valid_q;
	item_t item_q;
	logic  ready;
	logic  accept;

	assign ready  = !valid_q || !q_stat.full;
	assign busy   = !ready;
	assign accept = start && ready;
	assign push   = valid_q && !q_stat.full;
	assign item   = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= accept || (valid_q && !push);
		end
	end

	// The coordinate splits into a wrapping cell index and a fraction.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.xi <= x_coord[COORD_W-1:FRAC_BITS];
			item_q.yi <= y_coord[COORD_W-1:FRAC_BITS];
			item_q.zi <= z_coord[COORD_W-1:FRAC_BITS];
			item_q.xf <= x_coord[FRAC_BITS-1:0];
			item_q.yf <= y_coord[FRAC_BITS-1:0];
			item_q.zf <= z_coord[FRAC_BITS-1:0];
		end
	end

endmodule
`default_nettype wire

### design/ign3d_fifo.sv
`default_nettype none
module ign3d_fifo import ign3d_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t item_in,
	input  wire logic  pop,
	output item_t      item_out,
	output q_stat_t    stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign item_out   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= item_in;
		end
	end

endmodule
`default_nettype wire

### design/ign3d_back.sv
`default_nettype none
module ign3d_back import ign3d_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire item_t           item,
	output logic                 done,
	output logic signed [OUT_W-1:0] noise_value
);

	localparam int NST = 10;
	localparam logic signed [17:0] ONE18 = 18'sd65536;

	logic [NST:1] v_q;

	// Per axis: 0 is x, 1 is y, 2 is z.
	logic [FRAC_BITS-1:0]  f_s1 [3];
	logic [FRAC_BITS-1:0]  f_s2 [3];
	logic [FRAC_BITS-1:0]  f_s3 [3];
	logic [FRAC_BITS-1:0]  t2_s1 [3];
	logic [FRAC_BITS-1:0]  t3_s2 [3];
	logic signed [22:0]    kh_s2 [3];
	logic signed [17:0]    w_s3 [3];
	logic signed [17:0]    w_s4 [3];
	logic signed [17:0]    w_s5 [3];
	logic signed [17:0]    w_s6 [3];
	logic signed [17:0]    w_s7 [3];
	logic signed [17:0]    w_s8 [3];

	logic [7:0] yi_s1;
	logic [7:0] zi_s1;
	logic [7:0] zi_s2;
	logic [7:0] px_s1 [2];
	logic [7:0] q_s2 [4];
	logic [3:0] h_s3 [8];

	logic signed [18:0] g_s4 [8];
	logic signed [18:0] a_s5 [4];
	logic signed [23:0] p_s5 [4];
	logic signed [23:0] lx_s6 [4];
	logic signed [23:0] a_s7 [2];
	logic signed [23:0] p_s7 [2];
	logic signed [23:0] ly_s8 [2];
	logic signed [23:0] a_s9;
	logic signed [23:0] p_s9;
	logic signed [OUT_W-1:0] r_s10;

	logic signed [23:0] sum_s10;
	logic [FRAC_BITS-1:0] fin [3];

	assign fin[0] = item.xf;
	assign fin[1] = item.yf;
	assign fin[2] = item.zf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[NST-1:1], in_valid};
		end
	end

	// Ease curve, hash lookups and fraction pipeline.
	always_ff @(posedge clk) begin
		logic [31:0]        sq;
		logic [31:0]        cb;
		logic signed [21:0] lin;
		logic signed [38:0] kp;
		logic signed [22:0] k;
		logic signed [39:0] fp;
		for (int a = 0; a < 3; a++) begin
			sq = 32'(fin[a]) * 32'(fin[a]);
			f_s1[a]  <= fin[a];
			t2_s1[a] <= sq[31:16];

			cb  = 32'(t2_s1[a]) * 32'(f_s1[a]);
			lin = 22'sd6 * $signed({6'b0, f_s1[a]}) - 22'sd983040;
			kp  = 39'($signed({1'b0, f_s1[a]})) * 39'(lin);
			f_s2[a]  <= f_s1[a];
			t3_s2[a] <= cb[31:16];
			kh_s2[a] <= 23'(kp >>> FRAC_BITS);

			k  = kh_s2[a] + 23'sd655360;
			fp = 40'($signed({1'b0, t3_s2[a]})) * 40'(k);
			f_s3[a] <= f_s2[a];
			w_s3[a] <= 18'(fp >>> FRAC_BITS);

			w_s4[a] <= w_s3[a];
			w_s5[a] <= w_s4[a];
			w_s6[a] <= w_s5[a];
			w_s7[a] <= w_s6[a];
			w_s8[a] <= w_s7[a];
		end

		// Corner hashes; 8-bit sums wrap, which reads the table as doubled.
		yi_s1 <= item.yi;
		zi_s1 <= item.zi;
		for (int a = 0; a < 2; a++) begin
			px_s1[a] <= PERM_ROM[8'(item.xi + 8'(a))];
		end
		zi_s2 <= zi_s1;
		for (int c = 0; c < 4; c++) begin
			q_s2[c] <= PERM_ROM[8'(px_s1[c % 2] + 8'(yi_s1 + 8'(c / 2)))];
		end
		for (int c = 0; c < 8; c++) begin
			h_s3[c] <= PERM_ROM[8'(q_s2[c % 4] + 8'(zi_s2 + 8'(c / 4)))][3:0];
		end
	end

	// Gradient sums and trilinear blend.
	always_ff @(posedge clk) begin
		logic signed [17:0] ox;
		logic signed [17:0] oy;
		logic signed [17:0] oz;
		logic signed [19:0] d1;
		logic signed [37:0] m1;
		logic signed [24:0] d2;
		logic signed [42:0] m2;
		for (int c = 0; c < 8; c++) begin
			ox = $signed({2'b0, f_s3[0]}) - ((c % 2 == 1) ? ONE18 : 18'sd0);
			oy = $signed({2'b0, f_s3[1]}) - (((c / 2) % 2 == 1) ? ONE18 : 18'sd0);
			oz = $signed({2'b0, f_s3[2]}) - ((c / 4 == 1) ? ONE18 : 18'sd0);
			g_s4[c] <= grad_sum(h_s3[c], ox, oy, oz);
		end
		for (int p = 0; p < 4; p++) begin
			d1 = 20'(g_s4[2*p+1]) - 20'(g_s4[2*p]);
			m1 = 38'(d1) * 38'(w_s4[0]);
			a_s5[p] <= g_s4[2*p];
			p_s5[p] <= 24'(m1 >>> FRAC_BITS);
			lx_s6[p] <= 24'(a_s5[p]) + p_s5[p];
		end
		for (int p = 0; p < 2; p++) begin
			d2 = 25'(lx_s6[2*p+1]) - 25'(lx_s6[2*p]);
			m2 = 43'(d2) * 43'(w_s6[1]);
			a_s7[p]  <= lx_s6[2*p];
			p_s7[p]  <= 24'(m2 >>> FRAC_BITS);
			ly_s8[p] <= a_s7[p] + p_s7[p];
		end
		d2 = 25'(ly_s8[1]) - 25'(ly_s8[0]);
		m2 = 43'(d2) * 43'(w_s8[2]);
		a_s9 <= ly_s8[0];
		p_s9 <= 24'(m2 >>> FRAC_BITS);
		r_s10 <= (sum_s10 > 24'sd131071) ? 18'sd131071 :
			(sum_s10 < -24'sd131072) ? -18'sd131072 : 18'(sum_s10);
	end

	assign sum_s10     = a_s9 + p_s9;
	assign done        = v_q[NST];
	assign noise_value = r_s10;

endmodule
`default_nettype wire

### design/improved_gradient_noise_3d.sv
`default_nettype none
// Channel   Handshake                 Payload
// input     start (in), busy (out)    x_coord, y_coord, z_coord (Q8.16)
// result    done (out), one cycle     noise_value (signed Q2.16)
//
// An item is taken at a clock edge with start high and busy low, one per cycle.
// Each result appears as a one-cycle done strobe after its item has passed
// from the front register through the queue and the ten-stage back pipeline.
// The back pipeline never stalls because the receiver cannot hold results off,
// so the queue drains every cycle and busy stays low in normal operation.
// arst_n clears all valid and pointer state; no clearing pass is needed.
module improved_gradient_noise_3d import ign3d_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [COORD_W-1:0]  x_coord,
	input  wire logic [COORD_W-1:0]  y_coord,
	input  wire logic [COORD_W-1:0]  z_coord,
	output logic                     done,
	output logic signed [OUT_W-1:0]  noise_value
);

	// The front end registers the item and splits each coordinate into a
	// cell index and a fraction.
	q_stat_t q_stat;
	logic    q_push;
	logic    q_pop;
	item_t   front_item;
	item_t   back_item;

	ign3d_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.x_coord (x_coord),
		.y_coord (y_coord),
		.z_coord (z_coord),
		.q_stat  (q_stat),
		.busy    (busy),
		.push    (q_push),
		.item    (front_item)
	);

	// A short queue decouples the front register from the back pipeline.
	ign3d_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.item_in  (front_item),
		.pop      (q_pop),
		.item_out (back_item),
		.stat     (q_stat)
	);

	// The back pipeline takes an item whenever one waits.
	assign q_pop = !q_stat.empty;

	// The back pipeline eases fractions, hashes the corners and blends.
	ign3d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (q_pop),
		.item        (back_item),
		.done        (done),
		.noise_value (noise_value)
	);

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_stat.full))
		else $error("queue written while full");
	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |=> !q_stat.full)
		else $error("queue filled although the back end drains it");
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(q_push) |-> !busy)
		else $error("front end stalled behind a draining queue");
`endif

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import ign3d_pkg::*;

	// Clock, reset and the ports of the noise block.
	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [COORD_W-1:0] x_coord;
	logic [COORD_W-1:0] y_coord;
	logic [COORD_W-1:0] z_coord;
	logic done;
	logic signed [OUT_W-1:0] noise_value;

	improved_gradient_noise_3d dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.z_coord(z_coord),
		.done(done),
		.noise_value(noise_value)
	);

	localparam longint ONE = longint'(1) << FRAC_BITS;

	// One row of the directed table. When has_known is set, the noise value is
	// typed in directly; otherwise the predictor supplies it.
	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		bit has_known;
		logic signed [OUT_W-1:0] known;
	} noise_row_t;

	// Expected noise samples, oldest first.
	logic signed [OUT_W-1:0] pending_noise[$];
	// Value the directed row in flight wants, if it has one.
	bit row_known;
	logic signed [OUT_W-1:0] row_value;
	int fail_count;

	// Fixed-point product, dropping the low fraction bits toward minus infinity.
	function automatic longint fx_product(input longint a, input longint b);
		return (a * b) >>> FRAC_BITS;
	endfunction

	// Quintic ease curve 6t^5 - 15t^4 + 10t^3 with the same truncation order
	// as the block: t^3 first, then the quadratic factor, then their product.
	function automatic longint ease_curve(input longint t);
		longint cube;
		longint poly;
		cube = fx_product(fx_product(t, t), t);
		poly = fx_product(t, 6 * t - 15 * ONE) + 10 * ONE;
		return fx_product(cube, poly);
	endfunction

	function automatic longint lerp_fx(input longint a, input longint b, input longint w);
		return a + fx_product(w, b - a);
	endfunction

	// Corner hash through the permutation ROM; sums index it modulo 256, which
	// is what the doubled 512-entry table amounts to.
	function automatic logic [3:0] corner_hash(input int xi, input int yi, input int zi);
		int h;
		h = int'(PERM_ROM[xi & 255]);
		h = int'(PERM_ROM[(h + yi) & 255]);
		h = int'(PERM_ROM[(h + zi) & 255]);
		return h[3:0];
	endfunction

	// Gradient sum of one corner. Note that codes 12 to 15 repeat earlier
	// directions so that all sixteen codes map onto the twelve cube edges.
	function automatic longint gradient_dot(input logic [3:0] h, input longint dx,
			input longint dy, input longint dz);
		case (h)
			4'h0: return dx + dy;
			4'h1: return -dx + dy;
			4'h2: return dx - dy;
			4'h3: return -dx - dy;
			4'h4: return dx + dz;
			4'h5: return -dx + dz;
			4'h6: return dx - dz;
			4'h7: return -dx - dz;
			4'h8: return dy + dz;
			4'h9: return -dy + dz;
			4'hA: return dy - dz;
			4'hB: return -dy - dz;
			4'hC: return dy + dx;
			4'hD: return -dy + dz;
			4'hE: return dy - dx;
			default: return -dy - dz;
		endcase
	endfunction

	// Full noise sample for one coordinate triple, saturated to 18 bits.
	function automatic logic signed [OUT_W-1:0] noise_predict(input logic [COORD_W-1:0] cx,
			input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz);
		int xi, yi, zi, xn, yn, zn;
		longint xf, yf, zf, xg, yg, zg, u, v, w, a, b, lo, hi, r;
		xi = int'(cx[23:16]);
		yi = int'(cy[23:16]);
		zi = int'(cz[23:16]);
		// The cell at integer part 255 has its far corner at lattice index 0.
		xn = (xi + 1) & 255;
		yn = (yi + 1) & 255;
		zn = (zi + 1) & 255;
		xf = longint'(cx[15:0]);
		yf = longint'(cy[15:0]);
		zf = longint'(cz[15:0]);
		xg = xf - ONE;
		yg = yf - ONE;
		zg = zf - ONE;
		u = ease_curve(xf);
		v = ease_curve(yf);
		w = ease_curve(zf);
		a = lerp_fx(gradient_dot(corner_hash(xi, yi, zi), xf, yf, zf),
			gradient_dot(corner_hash(xn, yi, zi), xg, yf, zf), u);
		b = lerp_fx(gradient_dot(corner_hash(xi, yn, zi), xf, yg, zf),
			gradient_dot(corner_hash(xn, yn, zi), xg, yg, zf), u);
		lo = lerp_fx(a, b, v);
		a = lerp_fx(gradient_dot(corner_hash(xi, yi, zn), xf, yf, zg),
			gradient_dot(corner_hash(xn, yi, zn), xg, yf, zg), u);
		b = lerp_fx(gradient_dot(corner_hash(xi, yn, zn), xf, yg, zg),
			gradient_dot(corner_hash(xn, yn, zn), xg, yg, zg), u);
		hi = lerp_fx(a, b, v);
		r = lerp_fx(lo, hi, w);
		if (r > 131071) begin
			r = 131071;
		end
		if (r < -131072) begin
			r = -131072;
		end
		return r[OUT_W-1:0];
	endfunction

	// 10 ns clock.
	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Watchdog: far beyond the slowest correct run of about 1700 items, even
	// with the sender idle in about two thirds of the cycles of one phase.
	initial begin
		#3ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Acceptance and checking both happen on the rising edge. An item is taken
	// when start is high and busy low; its expected noise value is queued then.
	// Each done strobe is compared against the oldest queued value.
	always @(posedge clk) begin
		logic signed [OUT_W-1:0] want;
		if (arst_n && start && !busy) begin
			pending_noise.push_back(row_known ? row_value
				: noise_predict(x_coord, y_coord, z_coord));
		end
		if (arst_n && done) begin
			if (pending_noise.size() == 0) begin
				$display("%0t: unexpected noise_value: expected none, actual %0d",
					$time, noise_value);
				fail_count++;
			end else begin
				want = pending_noise.pop_front();
				if (noise_value !== want) begin
					$display("%0t: noise_value mismatch: expected %0d, actual %0d",
						$time, want, noise_value);
					fail_count++;
				end
			end
		end
	end

	// Present one item from the falling edge on and hold it until the block
	// takes it. Afterwards the sender stays idle in each following cycle with
	// the given chance in percent.
	task automatic send_item(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COORD_W-1:0] z, input int idle_pct);
		start = 1'b1;
		x_coord = x;
		y_coord = y;
		z_coord = z;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		@(negedge clk);
		row_known = 1'b0;
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
	endtask

	// Random coordinate, now and then on the edges of the unit cell or in cell
	// 255, since ease curve, corner offsets and wrap are most stressed there.
	function automatic logic [COORD_W-1:0] random_coord();
		logic [COORD_W-1:0] c;
		c = COORD_W'($urandom());
		case ($urandom_range(7))
			0: c[15:0] = 16'h0000;
			1: c[15:0] = 16'hFFFF;
			2: c[23:16] = 8'hFF;
			default: ;
		endcase
		return c;
	endfunction

	noise_row_t directed[$];
	int idle_levels[4] = '{0, 64, 14, 0};

	initial begin
		fail_count = 0;
		row_known = 1'b0;
		row_value = '0;
		arst_n = 1'b0;
		start = 1'b0;
		x_coord = '0;
		y_coord = '0;
		z_coord = '0;

		// Directed table. With all fractions at zero the sample sits on a
		// lattice point, where the noise is zero whatever the hash.
		directed = '{
			'{24'h000000, 24'h000000, 24'h000000, 1'b1, 18'sd0},
			'{24'hFF0000, 24'hFF0000, 24'hFF0000, 1'b1, 18'sd0},
			'{24'h7A0000, 24'h130000, 24'hC40000, 1'b1, 18'sd0},
			'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 18'sd0},
			'{24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 1'b0, 18'sd0},
			'{24'h000001, 24'h000001, 24'h000001, 1'b0, 18'sd0},
			'{24'h008000, 24'h008000, 24'h008000, 1'b0, 18'sd0},
			'{24'hFF8000, 24'h000000, 24'hFFFFFF, 1'b0, 18'sd0},
			'{24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b0, 18'sd0},
			'{24'h555555, 24'hAAAAAA, 24'h555555, 1'b0, 18'sd0},
			'{24'hFFFFFF, 24'h000000, 24'h000000, 1'b0, 18'sd0},
			'{24'h000000, 24'hFFFFFF, 24'h000000, 1'b0, 18'sd0},
			'{24'h000000, 24'h000000, 24'hFFFFFF, 1'b0, 18'sd0},
			'{24'h014000, 24'h02C000, 24'h034000, 1'b0, 18'sd0},
			'{24'h80FFFF, 24'h7F0001, 24'hFEC000, 1'b0, 18'sd0}
		};

		repeat (10) begin
			@(posedge clk);
		end
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows go back to back so the pipeline fills right away.
		foreach (directed[i]) begin
			row_known = directed[i].has_known;
			row_value = directed[i].known;
			send_item(directed[i].x, directed[i].y, directed[i].z, 0);
		end
		start = 1'b0;

		// Random phases at several sender idle rates. Between phases the
		// sender holds off until every queued result has come back.
		foreach (idle_levels[p]) begin
			while (pending_noise.size() != 0) begin
				@(negedge clk);
			end
			repeat (420) begin
				send_item(random_coord(), random_coord(), random_coord(), idle_levels[p]);
			end
			start = 1'b0;
		end

		// Drain, then allow the pipeline depth again for stray strobes.
		while (pending_noise.size() != 0) begin
			@(negedge clk);
		end
		repeat (20) begin
			@(posedge clk);
		end
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
`default_nettype wire
